// File: rtl/core/nps_pkg.sv
// Shared types and constants of the priority scheduler.
package nps_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int TIME_W      = 48;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic KIND_SERVED = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic [31:0] arrival_time;
        logic [31:0] run_time;
        logic [15:0] seniority;
        logic        last;
    } t_job;

    typedef struct packed {
        logic              kind;
        logic [15:0]       served_seniority;
        logic [TIME_W-1:0] service_start;
        logic [TIME_W-1:0] wait_res;
        logic [TIME_W-1:0] max_wait;
        logic              end_of_run;
    } t_result;

    typedef struct packed {
        logic [31:0] arrival;
        logic [31:0] run;
        logic [15:0] rank;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic head_ok;
        t_job head;
    } t_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SERVE,
        S_EMIT,
        S_INSERT,
        S_FLUSH
    } t_state;

endpackage

// File: rtl/core/nps_if.sv
// Valid/ready channel interfaces for jobs and results.
interface nps_job_if;
    logic          valid;
    logic          ready;
    nps_pkg::t_job data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nps_res_if;
    logic             valid;
    logic             ready;
    nps_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/nps_ram.sv
// Generic single-write, single-read RAM with registered read.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/nps_front.sv
// Front end: accepts job beats into a two-entry queue toward the back end.
module nps_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nps_job_if.sink            i_job,
    input  logic               i_pop,
    output nps_pkg::t_head     o_head
);
    import nps_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push;

    assign i_job.ready = (r_cnt != 2'd2);
    assign w_push      = i_job.valid && i_job.ready;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job.data;
        end
    end

    assign o_head.head_ok = (r_cnt != 2'd0);
    assign o_head.head    = r_mem[r_rp];
endmodule

// File: rtl/core/nps_back.sv
// Back end: queue store, lowest-rank scan, service timing and result staging.
module nps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nps_pkg::t_head i_head,
    output logic           o_pop,
    nps_res_if.source      o_res
);
    import nps_pkg::*;

    t_state                  r_state, n_state;
    t_job                    r_job;
    logic                    r_drain;
    logic [QIDX_W:0]         r_idx;
    logic [QUEUE_DEPTH-1:0]  r_valid;
    logic [TIME_W-1:0]       r_cur;
    logic [TIME_W-1:0]       r_worst;
    logic [TIME_W-1:0]       r_start;
    logic [TIME_W-1:0]       r_wait;
    logic                    r_best_ok;
    logic [QIDX_W-1:0]       r_best_slot;
    t_entry                  r_best;
    logic                    r_pend_ok;
    t_result                 r_pend;
    logic                    r_out_ok, n_out_ok;
    t_result                 r_out, n_out;

    logic [TIME_W-1:0]       w_arr;
    logic                    w_lt;
    logic                    w_any;
    logic                    w_full;
    logic [QIDX_W-1:0]       w_free;
    logic                    w_out_free;
    logic                    w_can_push;
    logic                    w_push;
    logic                    w_load;
    t_result                 w_new;
    logic                    w_we;
    t_entry                  w_wdata;
    logic [QIDX_W-1:0]       w_raddr;
    t_entry                  w_rdata;
    logic [QIDX_W-1:0]       w_k;
    logic                    w_take;
    logic [TIME_W:0]         w_sum;
    logic [TIME_W-1:0]       w_worst;

    nps_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_free),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_arr      = {{(TIME_W-32){1'b0}}, r_job.arrival_time};
    assign w_lt       = r_cur < w_arr;
    assign w_any      = |r_valid;
    assign w_full     = &r_valid;
    assign w_out_free = !r_out_ok || o_res.ready;
    assign w_can_push = !r_pend_ok || w_out_free;
    assign w_k        = QIDX_W'(r_idx - 1'b1);
    assign w_take     = r_valid[w_k] &&
                        (!r_best_ok || w_rdata.rank < r_best.rank ||
                         (w_rdata.rank == r_best.rank && w_rdata.arrival < r_best.arrival));
    assign w_sum      = {1'b0, r_cur} + {{(TIME_W-31){1'b0}}, r_best.run};
    assign w_worst    = (r_wait > r_worst) ? r_wait : r_worst;
    assign w_wdata    = '{arrival: r_job.arrival_time, run: r_job.run_time,
                          rank: r_job.seniority};

    always_comb begin
        w_free = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free = QIDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.head_ok) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_drain) n_state = w_any ? S_SCAN : S_FLUSH;
                else         n_state = (w_lt && w_any) ? S_SCAN : S_INSERT;
            end
            S_SCAN: begin
                if (r_idx == (QIDX_W+1)'(QUEUE_DEPTH)) n_state = S_SERVE;
            end
            S_SERVE: n_state = S_EMIT;
            S_EMIT: begin
                if (w_can_push) n_state = S_CHECK;
            end
            S_INSERT: begin
                if (!w_full || w_can_push) n_state = r_job.last ? S_CHECK : S_FLUSH;
            end
            S_FLUSH: begin
                if (!r_pend_ok || w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_push  = 1'b0;
        w_raddr = r_idx[QIDX_W-1:0];
        w_new   = '{kind: KIND_SERVED, served_seniority: r_best.rank,
                    service_start: r_start, wait_res: r_wait, max_wait: w_worst,
                    end_of_run: 1'b0};
        unique case (r_state)
            S_IDLE:   o_pop = i_head.head_ok;
            S_EMIT:   w_push = w_can_push;
            S_INSERT: begin
                w_we   = !w_full;
                w_push = w_full && w_can_push;
                w_new  = '{kind: KIND_REJECT, served_seniority: r_job.seniority,
                           service_start: '0, wait_res: '0, max_wait: r_worst,
                           end_of_run: 1'b0};
            end
            default: ;
        endcase
    end

    // output register load: advance the pending beat, mark the final one
    always_comb begin
        w_load = 1'b0;
        n_out  = r_pend;
        if (w_push && r_pend_ok) begin
            w_load = 1'b1;
        end else if (r_state == S_FLUSH && r_pend_ok && w_out_free) begin
            w_load           = 1'b1;
            n_out.end_of_run = 1'b1;
        end
        n_out_ok = w_load || (r_out_ok && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cur     <= '0;
            r_worst   <= '0;
            r_pend_ok <= 1'b0;
            r_out_ok  <= 1'b0;
            r_drain   <= 1'b0;
            r_best_ok <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state  <= n_state;
            r_out_ok <= n_out_ok;
            if (w_push) begin
                r_pend_ok <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: r_drain <= 1'b0;
                S_CHECK: begin
                    r_idx     <= '0;
                    r_best_ok <= 1'b0;
                    if (!r_drain && w_lt && !w_any) r_cur <= w_arr;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx != '0 && w_take) r_best_ok <= 1'b1;
                end
                S_SERVE: begin
                    r_cur <= w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
                    r_valid[r_best_slot] <= 1'b0;
                end
                S_EMIT: begin
                    if (w_can_push) r_worst <= w_worst;
                end
                S_INSERT: begin
                    if (!w_full) r_valid[w_free] <= 1'b1;
                    if (!w_full || w_can_push) r_drain <= r_job.last;
                end
                S_FLUSH: begin
                    if (r_pend_ok && w_out_free) begin
                        r_pend_ok <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_head.head;
        if (r_state == S_SCAN && r_idx != '0 && w_take) begin
            r_best      <= w_rdata;
            r_best_slot <= w_k;
        end
        if (r_state == S_SERVE) begin
            r_start <= r_cur;
            r_wait  <= (r_cur >= {{(TIME_W-32){1'b0}}, r_best.arrival})
                       ? r_cur - {{(TIME_W-32){1'b0}}, r_best.arrival} : '0;
        end
        if (w_push) begin
            r_pend <= w_new;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_ok;
    assign o_res.data  = r_out;
endmodule

// File: rtl/core/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler top level. Jobs enter a two-beat queue and
// are worked one at a time; each service scans all QUEUE_DEPTH slots of the job
// store, one slot a cycle through its read port, and the back end stalls while
// the receiver holds off results. Results leave through a registered output,
// and the final result of an item carries end_of_run.
module nonpreemptive_priority_scheduler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nps_job_if.sink   i_job,
    nps_res_if.source o_res
);
    import nps_pkg::*;

    t_head w_head;
    logic  w_pop;

    nps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (i_job),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    nps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

`ifndef NO_ASSERTIONS
    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.head_ok) else $error("pop from empty job queue");
    a_wait_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.kind == KIND_SERVED |->
        o_res.data.wait_res <= o_res.data.max_wait) else $error("wait above max");
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.kind == KIND_REJECT |->
        o_res.data.wait_res == '0 && o_res.data.service_start == '0)
        else $error("reject carries timing");
`endif
endmodule
